### rtl/acs_pkg.sv
// Package with shared types, constants and a helper function of the alarm countdown scheduler.
package acs_pkg;

    localparam int CHANNELS_DEF = 3;
    localparam int NUM_REGS     = 3;
    localparam int SET_W        = 26;
    localparam int WEEK_MIN     = 10080;
    localparam int DAY_MIN      = 24 * 60;
    localparam int ALARM_W      = 15;
    localparam int CD_W         = 9;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ARM    = 2'd1;
    localparam logic [1:0] FUNC_RESUME = 2'd2;
    localparam logic [1:0] FUNC_CLKSET = 2'd3;

    localparam logic [1:0] REP_ONCE   = 2'd0;
    localparam logic [1:0] REP_WEEKLY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAN,
        ST_DONE
    } acs_state_t;

    // Fields of one input beat.
    typedef struct packed {
        logic        sleep_locked;
        logic        alarm_muted;
        logic [15:0] elapsed_minutes;
        logic [5:0]  now_minute;
        logic [4:0]  now_hour;
        logic [2:0]  now_wday;
        logic [1:0]  channel;
        logic [1:0]  func;
    } acs_in_t;

    // Result of one pass of the channel unit.
    typedef struct packed {
        logic        enabled_next;
        logic [7:0]  left_next;
        logic        fired;
        logic        launch;
        logic        poff;
        logic        is_cd;
        logic        has_dist;
        logic [13:0] dist_min;
    } acs_unit_out_t;

    function automatic logic [7:0] cd_table(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd3;
            3'd1:    v = 8'd5;
            3'd2:    v = 8'd15;
            3'd3:    v = 8'd30;
            3'd4:    v = 8'd45;
            3'd5:    v = 8'd60;
            3'd6:    v = 8'd90;
            default: v = 8'd120;
        endcase
        return v;
    endfunction

endpackage

### rtl/alarm_countdown_scheduler.sv
// Flow: an accepted beat is held in item_reg, the shared channel unit visits one channel
// per cycle in ST_CHAN, and ST_DONE then loads the output register and raises m_tvalid.
// s_tready is low while a beat is being worked on and while its result waits in the
// output register, so a new beat is taken only after the last result has been taken.
// Reset (rst_n, asynchronous, active low) clears settings, enables and counts at once.
module alarm_countdown_scheduler
    import acs_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], channel[3:2], now_wday[6:4], now_hour[11:7], now_minute[17:12],
    // elapsed_minutes[33:18], alarm_muted[34], sleep_locked[35], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fired_mask[2:0], launch_mask[5:3], power_off[6], resched_valid[7],
    // next_alarm_minutes[22:8], next_countdown_minutes[31:23]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [SET_W-1:0] cfg_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    acs_state_t state_reg, state_next;
    logic [SET_W-1:0] setting_reg [CHANNELS];
    logic [CHANNELS-1:0] en_reg;
    logic [7:0] left_reg [CHANNELS];
    acs_in_t item_reg;
    logic [CW-1:0] ch_reg;
    logic prev_reg, valid_reg, poff_reg;
    logic [2:0] fired_reg, launch_reg;
    logic signed [ALARM_W-1:0] alarm_reg;
    logic signed [CD_W-1:0] cd_reg;
    logic m_valid_reg;
    logic [31:0] m_data_reg;

    acs_unit_out_t ures;
    logic act, first_two, selected, last_ch, alarm_better, cd_better, pass_valid;
    logic [SET_W-1:0] cur_set;

    assign cur_set   = setting_reg[ch_reg];
    assign act       = (ch_reg == '0) || !prev_reg;
    assign first_two = ({{(8-CW){1'b0}}, ch_reg} < 8'd2);
    assign selected  = ({{(8-CW){1'b0}}, ch_reg} == {6'd0, item_reg.channel});
    assign last_ch   = ({{(8-CW){1'b0}}, ch_reg} == 8'(CHANNELS - 1));

    acs_unit u_unit (
        .setting   (cur_set),
        .enabled   (en_reg[ch_reg]),
        .left      (left_reg[ch_reg]),
        .item      (item_reg),
        .act       (act),
        .first_two (first_two),
        .selected  (selected),
        .res       (ures)
    );

    // The minimum needs distances only for channels that will report them.
    assign alarm_better = ures.has_dist && !ures.is_cd &&
                          (alarm_reg < 0 || $signed({1'b0, ures.dist_min}) < alarm_reg);
    assign cd_better    = ures.has_dist && ures.is_cd &&
                          (cd_reg < 0 || $signed({1'b0, ures.dist_min[7:0]}) < cd_reg);
    assign pass_valid   = (item_reg.func != FUNC_TICK) &&
                          !(item_reg.func == FUNC_ARM &&
                            {6'd0, item_reg.channel} >= 8'(CHANNELS));

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready)
                    state_next = ST_CHAN;
            ST_CHAN:
                if (last_ch)
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            en_reg      <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            ch_reg      <= '0;
            prev_reg    <= 1'b0;
            item_reg    <= '0;
            fired_reg   <= 3'd0;
            launch_reg  <= 3'd0;
            poff_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            alarm_reg   <= -ALARM_W'(1);
            cd_reg      <= -CD_W'(1);
            for (int i = 0; i < CHANNELS; i++)
            begin
                setting_reg[i] <= '0;
                left_reg[i]    <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && {6'd0, cfg_index} < 8'(NUM_REGS) && {6'd0, cfg_index} < 8'(CHANNELS))
                setting_reg[CW'(cfg_index)] <= cfg_data;
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        item_reg   <= acs_in_t'(s_tdata[35:0]);
                        ch_reg     <= '0;
                        prev_reg   <= 1'b0;
                        fired_reg  <= 3'd0;
                        launch_reg <= 3'd0;
                        poff_reg   <= 1'b0;
                        valid_reg  <= 1'b0;
                        alarm_reg  <= -ALARM_W'(1);
                        cd_reg     <= -CD_W'(1);
                    end
                end
                ST_CHAN:
                begin
                    en_reg[ch_reg]   <= ures.enabled_next;
                    left_reg[ch_reg] <= ures.left_next;
                    prev_reg         <= ures.fired;
                    if (ures.fired && {{(8-CW){1'b0}}, ch_reg} < 8'd3)
                    begin
                        fired_reg[2'(ch_reg)]  <= 1'b1;
                        launch_reg[2'(ch_reg)] <= ures.launch;
                    end
                    if (ures.fired)
                        valid_reg <= 1'b1;
                    if (ures.poff)
                        poff_reg <= 1'b1;
                    if (alarm_better)
                        alarm_reg <= $signed({1'b0, ures.dist_min});
                    if (cd_better)
                        cd_reg <= $signed({1'b0, ures.dist_min[7:0]});
                    if (!last_ch)
                        ch_reg <= ch_reg + CW'(1);
                end
                ST_DONE:
                begin
                    m_valid_reg <= 1'b1;
                    if (valid_reg || pass_valid)
                        m_data_reg <= {cd_reg, alarm_reg, 1'b1, poff_reg, launch_reg, fired_reg};
                    else
                        m_data_reg <= {-CD_W'(1), -ALARM_W'(1), 1'b0, poff_reg,
                                       launch_reg, fired_reg};
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> m_valid_reg) else $error("result lost");
    a_arm_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !valid_reg && !pass_valid) |-> fired_reg == 3'd0)
        else $error("fired without reschedule");
`endif

endmodule

### rtl/acs_unit.sv
// Shared channel unit: evaluates one channel for tick, arm, resume, clock set and distance.
module acs_unit
    import acs_pkg::*;
(
    input  logic [SET_W-1:0] setting,
    input  logic             enabled,
    input  logic [7:0]       left,
    input  acs_in_t          item,
    input  logic             act,
    input  logic             first_two,
    input  logic             selected,
    output acs_unit_out_t    res
);

    logic       is_cd, is_alarm_fn, one_shot, match, wbit, any_fire;
    logic [1:0] rep;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [6:0] wmask;
    logic [7:0] left_dec, left_now;
    logic [2:0] days;
    logic       en_now;
    logic signed [15:0] d, dd;
    logic [13:0] wmask2;
    logic [6:0] shifted;
    logic        today;

    always_comb
    begin
        is_cd       = setting[0];
        is_alarm_fn = setting[1];
        rep         = setting[3:2];
        hr          = setting[8:4];
        mn          = setting[14:9];
        wmask       = setting[21:15];
        wbit        = (item.now_wday < 3'd7) ? wmask[item.now_wday] : 1'b0;

        en_now    = enabled;
        left_now  = left;
        any_fire  = 1'b0;
        one_shot  = 1'b1;
        left_dec  = left - 8'd1;
        match     = 1'b0;
        res       = '0;

        case (item.func)
            FUNC_TICK, FUNC_CLKSET:
            begin
                if (enabled && (item.func == FUNC_TICK || (first_two && !is_cd)))
                begin
                    if (is_cd)
                    begin
                        if (left != 8'd0)
                            left_now = left_dec;
                        any_fire = (left_now == 8'd0);
                    end
                    else
                    begin
                        match = (rep != REP_WEEKLY || wbit) && item.now_minute == mn
                                && item.now_hour == hr;
                        any_fire = match;
                        one_shot = (rep == REP_ONCE);
                    end
                end
                if (any_fire && one_shot)
                    en_now = 1'b0;
            end
            FUNC_ARM:
            begin
                if (selected)
                begin
                    en_now = setting[25];
                    if (setting[25] && is_cd)
                        left_now = cd_table(setting[24:22]);
                end
            end
            default:
            begin
                if (enabled && is_cd)
                    left_now = ({8'd0, left} > item.elapsed_minutes)
                               ? left - item.elapsed_minutes[7:0] : 8'd0;
            end
        endcase

        res.enabled_next = en_now;
        res.left_next    = left_now;
        res.fired        = any_fire;
        res.launch       = any_fire && act && is_alarm_fn && !item.alarm_muted;
        res.poff         = any_fire && act && !is_alarm_fn && !item.sleep_locked;
        res.is_cd        = is_cd;

        // Distance to next expiry, computed on updated state.
        d = (16'(signed'({1'b0, hr})) - 16'(signed'({1'b0, item.now_hour}))) * 16'sd60
            + (16'(signed'({1'b0, mn})) - 16'(signed'({1'b0, item.now_minute})));
        wmask2  = {wmask, wmask};
        shifted = 7'd0;
        days    = 3'd7;
        for (int k = 7; k >= 1; k--)
        begin
            // Weekday index after k days, wrapping to Sunday past Saturday.
            if (wmask2[((item.now_wday >= 3'd6) ? 0 : int'(item.now_wday) + 1) + k - 1])
                days = 3'(k);
        end
        today = item.now_hour < hr || (item.now_hour == hr && item.now_minute < mn);
        res.has_dist = en_now;
        dd = d;
        if (en_now && is_cd)
            dd = 16'(signed'({8'd0, left_now}));
        else if (en_now)
        begin
            if (today && (rep != REP_WEEKLY || wbit))
                dd = d;
            else if (rep == REP_WEEKLY)
            begin
                if (wmask == 7'd0)
                    res.has_dist = 1'b0;
                dd = 16'(signed'({13'd0, days})) * 16'sd1440 + d;
            end
            else
                dd = 16'sd1440 + d;
        end
        if (dd < 0)
            res.dist_min = 14'd0;
        else if (dd > 16'sd10080)
            res.dist_min = 14'd10080;
        else
            res.dist_min = dd[13:0];
        shifted = wmask;
        if (shifted == 7'h7f && days == 3'd0)
            res.has_dist = 1'b0;
    end

endmodule

### tb/sv/tb_alarm_countdown_scheduler.sv
// Self-checking testbench of the alarm countdown scheduler with random stimulus and stalls.
`timescale 1ns / 1ps

module tb_alarm_countdown_scheduler
    import acs_pkg::*;
;

    localparam int NCH         = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    // Fields of one result beat, as the block packs them into m_tdata.
    typedef struct packed {
        logic signed [8:0]  next_cd;
        logic signed [14:0] next_alarm;
        logic               resched;
        logic               power_off;
        logic [2:0]         launch;
        logic [2:0]         fired;
    } sched_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [SET_W-1:0]  cfg_data;

    alarm_countdown_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Free-running 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Shadow copy of the settings and channel state.
    logic [SET_W-1:0]  shadow_setting [NCH];
    logic              shadow_enabled [NCH];
    logic [7:0]        shadow_left    [NCH];

    acs_in_t           pending_beats[$];
    sched_result_t     expected_results[$];
    int                error_count;
    int                cycle_count;
    bit                quiet_mode;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Minutes until the channel's next expiry, -1 when it has none.
    function automatic int minutes_to_expiry(input int ch, input acs_in_t b);
        logic [SET_W-1:0] s;
        int h, m, d, days, w;
        s = shadow_setting[ch];
        days = 1;
        if (!shadow_enabled[ch])
            return -1;
        if (s[0])
            return int'(shadow_left[ch]);
        h = int'(s[8:4]);
        m = int'(s[14:9]);
        d = (h - int'(b.now_hour)) * 60 + (m - int'(b.now_minute));
        if (int'(b.now_hour) < h || (int'(b.now_hour) == h && int'(b.now_minute) < m))
        begin
            // Later today counts unless weekly with today's bit clear.
            if (s[3:2] != REP_WEEKLY || ((s[21:15] >> b.now_wday) & 1))
                return d < 0 ? 0 : (d > WEEK_MIN ? WEEK_MIN : d);
        end
        if (s[3:2] == REP_WEEKLY)
        begin
            if (s[21:15] == 7'd0)
                return -1;
            w = int'(b.now_wday);
            for (days = 1; days <= 7; days++)
            begin
                w = w + 1;
                if (w >= 7)
                    w = 0;
                if (s[15 + w])
                    break;
            end
        end
        d = days * DAY_MIN + d;
        return d < 0 ? 0 : (d > WEEK_MIN ? WEEK_MIN : d);
    endfunction

    // Tick evaluation of one channel: updates state, returns whether it expired.
    function automatic bit channel_expires(input int ch, input acs_in_t b, input bit acts,
                                           inout logic [2:0] launch, inout logic poff);
        logic [SET_W-1:0] s;
        bit one_shot;
        s = shadow_setting[ch];
        one_shot = 1'b1;
        if (!shadow_enabled[ch])
            return 1'b0;
        if (s[0])
        begin
            if (shadow_left[ch] > 0)
            begin
                shadow_left[ch]--;
                if (shadow_left[ch] > 0)
                    return 1'b0;
            end
        end
        else
        begin
            if (s[3:2] == REP_WEEKLY && !((s[21:15] >> b.now_wday) & 1))
                return 1'b0;
            if (b.now_minute != s[14:9] || b.now_hour != s[8:4])
                return 1'b0;
            if (s[3:2] != REP_ONCE)
                one_shot = 1'b0;
        end
        if (one_shot)
            shadow_enabled[ch] = 1'b0;
        if (acts)
        begin
            if (s[1])
            begin
                if (!b.alarm_muted)
                    launch[ch] = 1'b1;
            end
            else if (!b.sleep_locked)
                poff = 1'b1;
        end
        return 1'b1;
    endfunction

    // Applies one accepted beat to the shadow state and returns the expected result.
    function automatic sched_result_t schedule_step(input acs_in_t b);
        sched_result_t r;
        bit prev, cur;
        int v, best_alarm, best_cd;
        int e;
        r = '0;
        prev = 1'b0;
        best_alarm = -1;
        best_cd = -1;
        case (b.func)
            FUNC_TICK:
            begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    cur = channel_expires(ch, b, ch == 0 ? 1'b1 : !prev, r.launch, r.power_off);
                    if (cur)
                    begin
                        r.fired[ch] = 1'b1;
                        r.resched = 1'b1;
                    end
                    prev = cur;
                end
            end
            FUNC_ARM:
            begin
                if (b.channel < NCH)
                begin
                    shadow_enabled[b.channel] = shadow_setting[b.channel][25];
                    if (shadow_enabled[b.channel] && shadow_setting[b.channel][0])
                        shadow_left[b.channel] = cd_table(shadow_setting[b.channel][24:22]);
                    r.resched = 1'b1;
                end
            end
            FUNC_RESUME:
            begin
                e = int'(b.elapsed_minutes);
                for (int ch = 0; ch < NCH; ch++)
                    if (shadow_enabled[ch] && shadow_setting[ch][0])
                        shadow_left[ch] = int'(shadow_left[ch]) > e
                            ? 8'(int'(shadow_left[ch]) - e) : 8'd0;
                r.resched = 1'b1;
            end
            default:
            begin
                // Clock set checks only the alarm channels among the first two.
                for (int ch = 0; ch < 2; ch++)
                begin
                    cur = 1'b0;
                    if (!shadow_setting[ch][0])
                        cur = channel_expires(ch, b, ch == 0 ? 1'b1 : !prev,
                                              r.launch, r.power_off);
                    if (cur)
                        r.fired[ch] = 1'b1;
                    prev = cur;
                end
                r.resched = 1'b1;
            end
        endcase
        if (r.resched)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                v = minutes_to_expiry(ch, b);
                if (v < 0)
                    continue;
                if (!shadow_setting[ch][0])
                begin
                    if (best_alarm < 0 || v < best_alarm)
                        best_alarm = v;
                end
                else if (best_cd < 0 || v < best_cd)
                    best_cd = v;
            end
        end
        r.next_alarm = 15'(best_alarm);
        r.next_cd = 9'(best_cd);
        return r;
    endfunction

    // Acceptance seen at the last rising edge.
    logic s_tready_seen;

    // Driver: presents pending beats, with random idle bursts unless quiet.
    int     send_gap;
    acs_in_t cur_beat;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready_seen)
            begin
                // Previous beat was taken at the last rising edge.
                if (!quiet_mode && send_gap == 0 && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 12);
                if (pending_beats.size() > 0 && send_gap == 0)
                begin
                    cur_beat = pending_beats.pop_front();
                    s_tdata <= {4'd0, cur_beat};
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (!s_tvalid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_beats.size() > 0)
                begin
                    cur_beat = pending_beats.pop_front();
                    s_tdata  <= {4'd0, cur_beat};
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Acceptance sampled at the rising edge; the prediction runs here.
    always @(posedge clk)
    begin
        s_tready_seen <= 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            s_tready_seen <= 1'b1;
            expected_results.push_back(schedule_step(acs_in_t'(s_tdata[35:0])));
        end
    end

    // Receiver stalls.
    int recv_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: compares each result beat with the oldest expectation.
    sched_result_t got_result;
    sched_result_t want_result;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = sched_result_t'(m_tdata);
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat", int'(m_tdata), 0);
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result.fired != want_result.fired)
                    report_mismatch("fired_mask", got_result.fired, want_result.fired);
                if (got_result.launch != want_result.launch)
                    report_mismatch("launch_mask", got_result.launch, want_result.launch);
                if (got_result.power_off != want_result.power_off)
                    report_mismatch("power_off", got_result.power_off, want_result.power_off);
                if (got_result.resched != want_result.resched)
                    report_mismatch("resched_valid", got_result.resched, want_result.resched);
                if (got_result.next_alarm != want_result.next_alarm)
                    report_mismatch("next_alarm_minutes", got_result.next_alarm,
                                    want_result.next_alarm);
                if (got_result.next_cd != want_result.next_cd)
                    report_mismatch("next_countdown_minutes", got_result.next_cd,
                                    want_result.next_cd);
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic acs_in_t make_beat(input logic [1:0] f, input logic [1:0] ch,
                                          input int wd, input int hr, input int mn,
                                          input int el);
        acs_in_t b;
        b.func = f;
        b.channel = ch;
        b.now_wday = 3'(wd);
        b.now_hour = 5'(hr);
        b.now_minute = 6'(mn);
        b.elapsed_minutes = 16'(el);
        b.alarm_muted = 1'b0;
        b.sleep_locked = 1'b0;
        return b;
    endfunction

    // Settings word builder: countdown, alarm function, repeat, time, mask, choice, enable.
    function automatic logic [SET_W-1:0] make_setting(input bit cd, input bit alarm_fn,
                                                      input int rep, input int hr,
                                                      input int mn, input int wmask,
                                                      input int choice, input bit en);
        return {en, 3'(choice), 7'(wmask), 6'(mn), 5'(hr), 2'(rep), alarm_fn, cd};
    endfunction

    // Writes a setting while the block is idle; the shadow copy follows.
    task automatic write_setting(input int idx, input logic [SET_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= 2'(idx);
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_setting[idx] = value;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Arms every channel with the current settings.
    task automatic arm_all(input int hr, input int mn);
        for (int ch = 0; ch < NCH; ch++)
            pending_beats.push_back(make_beat(FUNC_ARM, 2'(ch), 1, hr, mn, 0));
    endtask

    // Random setting biased toward the current simulated time window.
    function automatic logic [SET_W-1:0] random_setting(input int hr, input int mn);
        if ($urandom_range(0, 9) == 0)
            return SET_W'($urandom());
        return make_setting($urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 3),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : hr,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                        : (mn + $urandom_range(0, 6)) % 60,
                            $urandom_range(0, 127), $urandom_range(0, 7),
                            $urandom_range(0, 5) != 0);
    endfunction

    int sim_wday, sim_hour, sim_minute;
    acs_in_t rb;
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        quiet_mode = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        s_tready_seen = 1'b0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            shadow_setting[ch] = '0;
            shadow_enabled[ch] = 1'b0;
            shadow_left[ch] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: one-shot countdown of 3 minutes, daily and weekly alarms.
        write_setting(0, make_setting(1, 0, 0, 0, 0, 0, 0, 1));
        write_setting(1, make_setting(0, 1, 2, 23, 59, 7'h41, 0, 1));
        write_setting(2, make_setting(0, 1, 3, 7, 30, 0, 7, 1));
        pending_beats.push_back(make_beat(FUNC_TICK, 0, 0, 0, 0, 0));
        arm_all(7, 29);
        pending_beats.push_back(make_beat(FUNC_ARM, 2'd3, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(FUNC_TICK, 0, 6, 23, 59, 0));
        pending_beats.push_back(make_beat(FUNC_TICK, 0, 7, 7, 30, 0));
        pending_beats.push_back(make_beat(FUNC_TICK, 0, 0, 23, 59, 0));
        pending_beats.push_back(make_beat(FUNC_RESUME, 0, 3, 31, 63, 65535));
        pending_beats.push_back(make_beat(FUNC_CLKSET, 0, 7, 7, 30, 0));
        rb = make_beat(FUNC_TICK, 0, 2, 7, 30, 0);
        rb.alarm_muted = 1'b1;
        rb.sleep_locked = 1'b1;
        pending_beats.push_back(rb);
        wait_idle();

        // Extremes: all-ones settings, then weekly with an empty mask.
        write_setting(0, '1);
        write_setting(1, make_setting(0, 0, 2, 10, 0, 0, 0, 1));
        write_setting(2, make_setting(1, 0, 0, 0, 0, 0, 7, 1));
        arm_all(10, 0);
        pending_beats.push_back(make_beat(FUNC_TICK, 0, 5, 31, 63, 0));
        pending_beats.push_back(make_beat(FUNC_CLKSET, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(FUNC_RESUME, 0, 0, 0, 0, 100));
        pending_beats.push_back(make_beat(FUNC_TICK, 0, 1, 10, 0, 0));
        wait_idle();

        // Random phases: new settings, arms, then a walk of minute ticks with noise.
        sim_wday = 0;
        sim_hour = 0;
        sim_minute = 0;
        for (int phase = 0; phase < 30; phase++)
        begin
            quiet_mode = (phase >= 26);
            for (int ch = 0; ch < NCH; ch++)
                if ($urandom_range(0, 2) != 0)
                    write_setting(ch, random_setting(sim_hour, sim_minute));
            arm_all(sim_hour, sim_minute);
            for (int k = 0; k < 27; k++)
            begin
                sim_minute++;
                if (sim_minute == 60)
                begin
                    sim_minute = 0;
                    sim_hour = (sim_hour + 1) % 24;
                    if (sim_hour == 0)
                        sim_wday = (sim_wday + 1) % 7;
                end
                rb = make_beat(FUNC_TICK, 0, sim_wday, sim_hour, sim_minute, 0);
                case ($urandom_range(0, 11))
                    0: rb.func = FUNC_ARM;
                    1: rb.func = FUNC_RESUME;
                    2: rb.func = FUNC_CLKSET;
                    3: rb = acs_in_t'({$urandom(), 4'($urandom())});
                    default: ;
                endcase
                rb.elapsed_minutes = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                                 : 16'($urandom_range(0, 8));
                rb.channel = 2'($urandom_range(0, 3));
                rb.alarm_muted = $urandom_range(0, 3) == 0;
                rb.sleep_locked = $urandom_range(0, 3) == 0;
                pending_beats.push_back(rb);
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
